### rtl/core/spq_pkg.sv
// Shared types, constants and a helper function for the sorted priority queue.
// Depends on nothing; included by wildcard import in the core module.
package spq_pkg;

    // Queue geometry and field widths.
    localparam int DEPTH   = 16;
    localparam int TAG_W   = 16;
    localparam int LEVEL_W = 2;
    localparam int OCC_W   = 5;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int WGT_W   = 4;

    // Priority codes.
    localparam logic [LEVEL_W-1:0] LVL_SERIOUS    = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_NONSERIOUS = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_CHECKUP    = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_INVALID    = 2'd3;

    // Action codes.
    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_DEQUEUE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_DEQ_HEAD,
        S_DEQ_MV,
        S_DONE
    } t_state;

    // One stored entry.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [TAG_W-1:0]   tag;
    } t_entry;

    // Weight of a priority code; the invalid code folds onto serious.
    function automatic logic [WGT_W-1:0] level_weight(input logic [LEVEL_W-1:0] lvl);
        logic [WGT_W-1:0] w;
        case (lvl)
            LVL_SERIOUS:    w = 4'd10;
            LVL_NONSERIOUS: w = 4'd5;
            LVL_CHECKUP:    w = 4'd1;
            default:        w = 4'd10;
        endcase
        return w;
    endfunction

endpackage

### rtl/core/sorted_priority_queue.sv
// Steps: an enqueue reads and compares the entries ahead of its insertion point one at a time,
// moving each it passes back a place, then writes the new entry; a dequeue reads the head, then
// moves the rest up one place; a status-only result goes straight to the done state. Throughput:
// one item at a time; the next transfer is taken in the cycle after the result is loaded, and
// loading waits under output stall. The memory's one read port and one weight comparator set it.
// Reset (i_rst_n low, synchronous) empties the queue and clears the output valid. Uses spq_pkg.
module sorted_priority_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_action,
    input  logic [spq_pkg::TAG_W-1:0]    i_tag,
    input  logic [spq_pkg::LEVEL_W-1:0]  i_level,
    // Output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_status,
    output logic [spq_pkg::TAG_W-1:0]    o_out_tag,
    output logic [spq_pkg::LEVEL_W-1:0]  o_out_level,
    output logic [spq_pkg::OCC_W-1:0]    o_occupancy
);
    import spq_pkg::*;

    // Entry memory and its registered read port.
    t_entry              mem [DEPTH];
    t_entry              r_rd_data;
    logic                mem_we;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_wa;
    logic [ADDR_W-1:0]   mem_ra;
    t_entry              mem_wd;

    // Sequencer and working registers.
    t_state              r_state,   n_state;
    logic [CNT_W-1:0]    r_count,   n_count;
    logic [CNT_W-1:0]    r_pos,     n_pos;
    t_entry              r_item,    n_item;
    t_status             r_res_st,  n_res_st;
    t_entry              r_res_ent, n_res_ent;

    // Output register.
    logic                r_out_valid, n_out_valid;
    t_status             r_out_st,    n_out_st;
    t_entry              r_out_ent,   n_out_ent;
    logic [OCC_W-1:0]    r_out_occ,   n_out_occ;

    logic                out_free;
    logic [CNT_W-1:0]    pos_m1;
    logic [CNT_W-1:0]    pos_p1;
    logic [OCC_W+CNT_W-1:0] occ_ext;

    assign out_free = !r_out_valid || !i_out_stall;
    assign pos_m1   = r_pos - CNT_W'(1);
    assign pos_p1   = r_pos + CNT_W'(1);
    assign occ_ext  = {{OCC_W{1'b0}}, r_count};

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_item    <= n_item;
        r_res_st  <= n_res_st;
        r_res_ent <= n_res_ent;
        r_out_st  <= n_out_st;
        r_out_ent <= n_out_ent;
        r_out_occ <= n_out_occ;
    end

    // Sequencer: next state, memory control and result staging.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_item      = r_item;
        n_res_st    = r_res_st;
        n_res_ent   = r_res_ent;
        n_out_st    = r_out_st;
        n_out_ent   = r_out_ent;
        n_out_occ   = r_out_occ;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_wa      = '0;
        mem_ra      = '0;
        mem_wd      = r_item;
        o_in_stall  = (r_state != S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item    = '{level: i_level, tag: i_tag};
                    n_res_ent = '0;
                    n_res_st  = ST_OK;
                    n_state   = S_DONE;
                    if (i_action == ACT_ENQUEUE) begin
                        if (i_level == LVL_INVALID) begin
                            n_res_st = ST_INVALID;
                        end else if (r_count == CNT_W'(DEPTH)) begin
                            n_res_st = ST_FULL;
                        end else if (r_count == '0) begin
                            // Empty queue: the entry lands at the head directly.
                            n_pos   = '0;
                            n_state = S_INS_PUT;
                        end else begin
                            n_pos   = r_count;
                            n_state = S_INS_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res_st = ST_EMPTY;
                        end else begin
                            mem_re  = 1'b1;
                            mem_ra  = '0;
                            n_state = S_DEQ_HEAD;
                        end
                    end
                end
            end

            S_INS_RD: begin
                // Fetch the entry just ahead of the insertion point.
                mem_re  = 1'b1;
                mem_ra  = pos_m1[ADDR_W-1:0];
                n_state = S_INS_CMP;
            end

            S_INS_CMP: begin
                // The new entry passes only strictly lower priority entries.
                if (level_weight(r_item.level) > level_weight(r_rd_data.level)) begin
                    mem_we = 1'b1;
                    mem_wa = r_pos[ADDR_W-1:0];
                    mem_wd = r_rd_data;
                    n_pos  = pos_m1;
                    if (pos_m1 == '0) begin
                        n_state = S_INS_PUT;
                    end else begin
                        n_state = S_INS_RD;
                    end
                end else begin
                    n_state = S_INS_PUT;
                end
            end

            S_INS_PUT: begin
                mem_we  = 1'b1;
                mem_wa  = r_pos[ADDR_W-1:0];
                mem_wd  = r_item;
                n_count = r_count + CNT_W'(1);
                n_state = S_DONE;
            end

            S_DEQ_HEAD: begin
                // Capture the head, then start moving the rest up one place.
                n_res_ent = r_rd_data;
                n_pos     = CNT_W'(1);
                if (r_count > CNT_W'(1)) begin
                    mem_re  = 1'b1;
                    mem_ra  = ADDR_W'(1);
                    n_state = S_DEQ_MV;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end

            S_DEQ_MV: begin
                // Write the entry read last cycle one place up, read the next.
                mem_we = 1'b1;
                mem_wa = pos_m1[ADDR_W-1:0];
                mem_wd = r_rd_data;
                if (pos_p1 < r_count) begin
                    mem_re = 1'b1;
                    mem_ra = pos_p1[ADDR_W-1:0];
                    n_pos  = pos_p1;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                // Hand the result to the output register once it is free.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_res_st;
                    n_out_ent   = r_res_ent;
                    n_out_occ   = occ_ext[OCC_W-1:0];
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_st;
    assign o_out_tag   = r_out_ent.tag;
    assign o_out_level = r_out_ent.level;
    assign o_occupancy = r_out_occ;

    // The count never exceeds the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    // An empty report always comes with zero occupancy and a zero tag.
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_EMPTY) |-> (o_occupancy == '0 && o_out_tag == '0))
        else $error("empty result with nonzero occupancy or tag");

    // A dequeued entry never carries the invalid priority code.
    a_deq_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OK) |-> (o_out_level != LVL_INVALID))
        else $error("dequeued entry has invalid priority");

    // The count changes only while an item is being worked on.
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> ($stable(r_count) || $past(i_in_valid)))
        else $error("entry count changed without an item");
endmodule

### test/tb_sorted_priority_queue.sv
// Self-checking testbench for the sorted priority queue: directed and random
// enqueue/dequeue traffic checked against an in-bench queue predictor.
// Depends on spq_pkg and sorted_priority_queue.
module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 50;

    // One expected result of the block.
    typedef struct {
        t_status            status;
        logic [TAG_W-1:0]   tag;
        logic [LEVEL_W-1:0] level;
        logic [OCC_W-1:0]   occ;
    } t_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_action = ACT_ENQUEUE;
    logic [TAG_W-1:0]     i_tag = '0;
    logic [LEVEL_W-1:0]   i_level = LVL_SERIOUS;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [1:0]           o_status;
    logic [TAG_W-1:0]     o_out_tag;
    logic [LEVEL_W-1:0]   o_out_level;
    logic [OCC_W-1:0]     o_occupancy;

    // Predicted queue contents, head at index 0.
    logic [TAG_W-1:0]     held_tags [DEPTH];
    logic [LEVEL_W-1:0]   held_levels [DEPTH];
    int                   held_count = 0;

    t_result              expected_results [$];
    int                   error_count = 0;
    int                   cycle_count = 0;
    bit                   idle_on = 1'b1;

    sorted_priority_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_tag       (i_tag),
        .i_level     (i_level),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_out_tag   (o_out_tag),
        .o_out_level (o_out_level),
        .o_occupancy (o_occupancy)
    );

    // Clock with a period of 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // Applies one item to the predicted queue and returns its result.
    function automatic t_result queue_update(input logic act, input logic [TAG_W-1:0] tag,
                                             input logic [LEVEL_W-1:0] lvl);
        t_result r;
        int      pos;
        r.status = ST_OK;
        r.tag    = '0;
        r.level  = LVL_SERIOUS;
        if (act == ACT_ENQUEUE) begin
            if (lvl == LVL_INVALID) begin
                r.status = ST_INVALID;
            end else if (held_count == DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // Move past every entry of lower priority, so equal levels stay FIFO.
                pos = held_count;
                while (pos > 0 && held_levels[pos-1] > lvl) begin
                    held_tags[pos]   = held_tags[pos-1];
                    held_levels[pos] = held_levels[pos-1];
                    pos--;
                end
                held_tags[pos]   = tag;
                held_levels[pos] = lvl;
                held_count++;
            end
        end else if (held_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.tag   = held_tags[0];
            r.level = held_levels[0];
            for (int i = 1; i < held_count; i++) begin
                held_tags[i-1]   = held_tags[i];
                held_levels[i-1] = held_levels[i];
            end
            held_count--;
        end
        r.occ = held_count[OCC_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [TAG_W-1:0] want,
                               input logic [TAG_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Compares each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d tag %0h",
                         $time, o_status, o_out_tag);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", TAG_W'(want.status), TAG_W'(o_status));
                check_field("out_tag", want.tag, o_out_tag);
                check_field("out_level", TAG_W'(want.level), TAG_W'(o_out_level));
                check_field("occupancy", TAG_W'(want.occ), TAG_W'(o_occupancy));
            end
        end
    end

    // Output stall in random bursts while idling is enabled.
    always begin
        @(posedge i_clk);
        if (idle_on && i_rst_n && $urandom_range(0, 4) == 0) begin
            i_out_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    // Sends one item, with an optional gap first, and records its expected result.
    task automatic send_item(input logic act, input logic [TAG_W-1:0] tag,
                             input logic [LEVEL_W-1:0] lvl);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_tag      <= tag;
        i_level    <= lvl;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(queue_update(act, tag, lvl));
    endtask

    // Empty queue: dequeue reports empty, invalid level is rejected.
    task automatic test_empty_and_invalid();
        send_item(ACT_DEQUEUE, 16'hFFFF, LVL_INVALID);
        send_item(ACT_ENQUEUE, 16'h1234, LVL_INVALID);
    endtask

    // Fill with mixed levels, then hit the full and invalid-while-full cases.
    task automatic test_fill_to_full();
        logic [LEVEL_W-1:0] pattern [16] = '{LVL_CHECKUP, LVL_NONSERIOUS, LVL_SERIOUS,
            LVL_CHECKUP, LVL_NONSERIOUS, LVL_SERIOUS, LVL_SERIOUS, LVL_NONSERIOUS,
            LVL_CHECKUP, LVL_CHECKUP, LVL_SERIOUS, LVL_NONSERIOUS, LVL_NONSERIOUS,
            LVL_SERIOUS, LVL_CHECKUP, LVL_SERIOUS};
        logic [TAG_W-1:0] tag;
        for (int i = 0; i < DEPTH; i++) begin
            tag = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : TAG_W'($urandom);
            send_item(ACT_ENQUEUE, tag, pattern[i % 16]);
        end
        send_item(ACT_ENQUEUE, 16'hAAAA, LVL_SERIOUS);
        // The invalid check takes precedence over the full check.
        send_item(ACT_ENQUEUE, 16'h5555, LVL_INVALID);
    endtask

    // Remove a few heads; tag and level fields on a dequeue are ignored.
    task automatic test_partial_drain();
        for (int i = 0; i < 4; i++)
            send_item(ACT_DEQUEUE, TAG_W'($urandom), LEVEL_W'($urandom_range(0, 3)));
    endtask

    // Random traffic that swings between filling and draining the queue.
    task automatic test_random_traffic(input int count);
        bit                 filling;
        logic               act;
        logic [LEVEL_W-1:0] lvl;
        filling = 1'b1;
        for (int i = 0; i < count; i++) begin
            // A quiet stretch in the middle with no idling on either side.
            idle_on = !(i >= count / 2 && i < count / 2 + 150);
            if (held_count == DEPTH && $urandom_range(0, 2) == 0)
                filling = 1'b0;
            else if (held_count == 0 && $urandom_range(0, 2) == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 39) == 0)
                filling = !filling;
            if (filling)
                act = ($urandom_range(0, 3) == 0) ? ACT_DEQUEUE : ACT_ENQUEUE;
            else
                act = ($urandom_range(0, 3) == 0) ? ACT_ENQUEUE : ACT_DEQUEUE;
            lvl = ($urandom_range(0, 15) == 0) ? LVL_INVALID : LEVEL_W'($urandom_range(0, 2));
            send_item(act, TAG_W'($urandom), lvl);
        end
    endtask

    // Back-to-back transfers with no idling on either side.
    task automatic test_steady_stream(input int count);
        idle_on = 1'b0;
        for (int i = 0; i < count; i++)
            send_item($urandom_range(0, 1) ? ACT_DEQUEUE : ACT_ENQUEUE, TAG_W'($urandom),
                      LEVEL_W'($urandom_range(0, 3)));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_and_invalid();
        test_fill_to_full();
        test_partial_drain();
        test_random_traffic(1700);
        test_steady_stream(300);
        i_in_valid <= 1'b0;
        // Wait for outstanding results, then for any stray late ones.
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
